@@ hdl/linked_block_chain_manager_top_assert.svh @@
// assertion macros for the linked block chain manager
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef LINKED_BLOCK_CHAIN_MANAGER_TOP_ASSERT_SVH
`define LINKED_BLOCK_CHAIN_MANAGER_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define LBCM_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LBCM_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/lbcm_pkg.sv @@
// shared constants, types and helpers for the linked block chain manager
// no dependencies
`timescale 1ns / 1ps

package lbcm_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 64;
    localparam int BLOCK_SIZE = 128;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = BLK_W + 1;
    localparam int OFF_W      = $clog2(BLOCK_SIZE);

    // item field widths
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 14;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = 13;
    localparam int CNT_W   = 7;
    localparam int NEED_W  = BYTE_W - OFF_W + 1;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 40;
    localparam int M_USED_W  = STAT_W + 3 * LINK_W + ADDR_W;

    // end of chain / empty / none
    localparam logic [LINK_W-1:0] NONE_MARK = LINK_W'(NUM_BLOCKS);

    typedef enum logic [KIND_W-1:0] {
        K_EXTEND = 2'd0,
        K_FREE   = 2'd1,
        K_LOCATE = 2'd2
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_BEYOND  = 2'd2
    } t_status;

    // one table entry
    typedef struct packed {
        logic              used;
        logic [LINK_W-1:0] link;
    } t_entry;

    // any block number outside the table ends a chain
    function automatic logic is_end(input logic [LINK_W-1:0] b);
        return b >= NONE_MARK;
    endfunction

endpackage

@@ hdl/linked_block_chain_manager_top.sv @@
// linked block chain manager: extend, free and locate on a linked block table
// depends on lbcm_pkg and linked_block_chain_manager_top_assert.svh
//
// channel | dir | tdata (low bit up)                               | tuser
// --------+-----+--------------------------------------------------+-------
// s_axis  | in  | head_block, byte_count, pad                      | kind
// m_axis  | out | status, new_head, block_index, byte_address,     | -
//         |     | block_count, pad                                 |
//
// one item at a time; the table sits in one memory with one read and one write
// port, and every chain step or table scan takes one entry read per cycle.
// extend walks the chain and, when it is short, counts free blocks and then, if
// enough are free, scans the table again to allocate them. free walks the chain
// and frees each block; locate walks the skipped links; unknown kind: no walk.
// reset (synchronous, active low) marks every block free through per-entry valid
// bits at once; no clearing pass. a held result does not block the next item
// until that item is finished.
`timescale 1ns / 1ps
`include "linked_block_chain_manager_top_assert.svh"

module linked_block_chain_manager_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // head_block [6:0], byte_count [20:7], zero pad [23:21]
    input  logic [lbcm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // kind [1:0]
    input  logic [lbcm_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status [1:0], new_head [8:2], block_index [15:9], byte_address [28:16],
    // block_count [35:29], zero pad [39:36]
    output logic [lbcm_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import lbcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_COUNT,
        S_ALLOC,
        S_CLOSE,
        S_FIN
    } t_state;

    localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(NUM_BLOCKS - 1);

    // table memory with per-entry valid bits
    t_entry             r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    logic               r_byp;
    t_entry             r_byp_data;
    logic               wr_en;
    logic [BLK_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic [BLK_W-1:0]   rd_addr;
    t_entry             q;

    // control and work registers
    t_state             r_state, n_state;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [LINK_W-1:0]  r_cur, n_cur;
    logic [LINK_W-1:0]  r_tail, n_tail;
    logic               r_tail_used, n_tail_used;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [NEED_W-1:0]  r_want, n_want;
    logic [CNT_W-1:0]   r_steps, n_steps;
    logic [CNT_W-1:0]   r_fcnt, n_fcnt;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BLK_W-1:0]   r_idx, n_idx;
    logic [BLK_W-1:0]   r_pend, n_pend;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [LINK_W-1:0]  r_newhead, n_newhead;
    logic [LINK_W-1:0]  r_index, n_index;
    logic [ADDR_W-1:0]  r_addr, n_addr;

    // output register
    logic               r_m_valid, n_m_valid;
    logic [STAT_W-1:0]  r_o_status, n_o_status;
    logic [LINK_W-1:0]  r_o_newhead, n_o_newhead;
    logic [LINK_W-1:0]  r_o_index, n_o_index;
    logic [ADDR_W-1:0]  r_o_addr, n_o_addr;
    logic [CNT_W-1:0]   r_o_count, n_o_count;

    // input unpacking
    logic               acc_in;
    logic [LINK_W-1:0]  in_head;
    logic [LINK_W-1:0]  in_head_n;
    logic [BYTE_W-1:0]  in_bytes;
    logic [KIND_W-1:0]  in_kind;
    logic [BYTE_W:0]    in_round;
    logic               cur_ok;
    logic [CNT_W-1:0]   steps_inc;
    logic [CNT_W-1:0]   have;
    logic [CNT_W-1:0]   fc_inc;
    logic [CNT_W-1:0]   cnt_inc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign in_head       = s_axis_tdata[LINK_W-1:0];
    assign in_bytes      = s_axis_tdata[LINK_W +: BYTE_W];
    assign in_kind       = s_axis_tuser[KIND_W-1:0];
    assign in_head_n     = is_end(in_head) ? NONE_MARK : in_head;
    assign in_round      = {1'b0, in_bytes} + (BYTE_W + 1)'(BLOCK_SIZE - 1);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, r_o_count, r_o_addr,
                            r_o_index, r_o_newhead, r_o_status};

    // read data with same-cycle write forwarding; unwritten entries read as free
    always_comb begin
        if (r_byp) begin
            q = r_byp_data;
        end else if (r_rd_vld) begin
            q = r_rd_data;
        end else begin
            q = t_entry'{used: 1'b0, link: NONE_MARK};
        end
    end

    assign cur_ok    = !is_end(r_cur);
    assign steps_inc = r_steps + 1'b1;
    assign have      = cur_ok ? steps_inc : r_steps;
    assign fc_inc    = r_fcnt + CNT_W'(!q.used);
    assign cnt_inc   = r_cnt + 1'b1;

    // next state and memory access
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_cur       = r_cur;
        n_tail      = r_tail;
        n_tail_used = r_tail_used;
        n_off       = r_off;
        n_need      = r_need;
        n_want      = r_want;
        n_steps     = r_steps;
        n_fcnt      = r_fcnt;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_status    = r_status;
        n_newhead   = r_newhead;
        n_index     = r_index;
        n_addr      = r_addr;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_o_status  = r_o_status;
        n_o_newhead = r_o_newhead;
        n_o_index   = r_o_index;
        n_o_addr    = r_o_addr;
        n_o_count   = r_o_count;
        rd_addr     = r_cur[BLK_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_cur[BLK_W-1:0];
        wr_data     = t_entry'{used: 1'b0, link: NONE_MARK};

        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_kind      = in_kind;
                    n_cur       = in_head_n;
                    n_newhead   = in_head_n;
                    n_off       = in_bytes[OFF_W-1:0];
                    n_need      = (in_kind == K_LOCATE)
                                  ? NEED_W'(in_bytes[BYTE_W-1:OFF_W])
                                  : in_round[BYTE_W:OFF_W];
                    n_steps     = '0;
                    n_cnt       = '0;
                    n_tail      = NONE_MARK;
                    n_tail_used = 1'b0;
                    n_status    = STAT_OK;
                    n_index     = NONE_MARK;
                    n_addr      = '0;
                    rd_addr     = in_head_n[BLK_W-1:0];
                    if (in_kind == K_EXTEND || in_kind == K_FREE || in_kind == K_LOCATE) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            // one chain link per cycle
            S_WALK: begin
                unique case (r_kind)
                    K_EXTEND: begin
                        if (cur_ok) begin
                            n_steps     = steps_inc;
                            n_tail      = r_cur;
                            n_tail_used = q.used;
                            n_cur       = q.link;
                            rd_addr     = q.link[BLK_W-1:0];
                        end
                        if (!cur_ok || is_end(q.link) || steps_inc == CNT_W'(NUM_BLOCKS)) begin
                            if ({1'b0, have} < r_need) begin
                                n_want  = r_need - {1'b0, have};
                                n_idx   = '0;
                                n_fcnt  = '0;
                                rd_addr = '0;
                                n_state = S_COUNT;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    end
                    K_FREE: begin
                        if (cur_ok) begin
                            wr_en   = 1'b1;
                            wr_addr = r_cur[BLK_W-1:0];
                            wr_data = t_entry'{used: 1'b0, link: NONE_MARK};
                            n_steps = steps_inc;
                            n_cnt   = steps_inc;
                            n_cur   = q.link;
                            rd_addr = q.link[BLK_W-1:0];
                        end
                        if (!cur_ok || is_end(q.link) || steps_inc == CNT_W'(NUM_BLOCKS)) begin
                            n_newhead = NONE_MARK;
                            n_state   = S_FIN;
                        end
                    end
                    K_LOCATE: begin
                        if (!cur_ok) begin
                            n_status = STAT_BEYOND;
                            n_state  = S_FIN;
                        end else if ({1'b0, r_steps} == r_need) begin
                            n_index = r_cur;
                            n_addr  = {r_cur[BLK_W-1:0], r_off};
                            n_state = S_FIN;
                        end else begin
                            n_steps = steps_inc;
                            n_cur   = q.link;
                            rd_addr = q.link[BLK_W-1:0];
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            // count free blocks until enough are seen or the last block is passed
            S_COUNT: begin
                n_fcnt  = fc_inc;
                n_idx   = r_idx + 1'b1;
                rd_addr = r_idx + 1'b1;
                if ({1'b0, fc_inc} >= r_want) begin
                    n_idx   = '0;
                    rd_addr = '0;
                    n_cnt   = '0;
                    n_state = S_ALLOC;
                end else if (r_idx == LAST_BLK) begin
                    n_status = STAT_NOSPACE;
                    n_state  = S_FIN;
                end
            end

            // take the lowest free blocks; each link is written when the next is found
            S_ALLOC: begin
                n_idx   = r_idx + 1'b1;
                rd_addr = r_idx + 1'b1;
                if (!q.used) begin
                    n_pend = r_idx;
                    n_cnt  = cnt_inc;
                    if (r_cnt == '0) begin
                        n_index = {1'b0, r_idx};
                        if (!is_end(r_tail)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_tail[BLK_W-1:0];
                            wr_data = t_entry'{used: (r_tail[BLK_W-1:0] == r_idx) || r_tail_used,
                                               link: {1'b0, r_idx}};
                        end else begin
                            n_newhead = {1'b0, r_idx};
                        end
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_pend;
                        wr_data = t_entry'{used: 1'b1, link: {1'b0, r_idx}};
                    end
                    if ({1'b0, cnt_inc} == r_want) begin
                        n_state = S_CLOSE;
                    end
                end
            end

            // terminate the last new block, unless it is the old tail linked to itself
            S_CLOSE: begin
                if (!(r_cnt == CNT_W'(1) && r_tail == {1'b0, r_pend})) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend;
                    wr_data = t_entry'{used: 1'b1, link: NONE_MARK};
                end
                n_state = S_FIN;
            end

            // hand the result to the output register
            S_FIN: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid   = 1'b1;
                    n_o_status  = r_status;
                    n_o_newhead = r_newhead;
                    n_o_index   = r_index;
                    n_o_addr    = r_addr;
                    n_o_count   = r_cnt;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_m_valid   <= n_m_valid;
            r_kind      <= n_kind;
            r_cur       <= n_cur;
            r_tail      <= n_tail;
            r_tail_used <= n_tail_used;
            r_off       <= n_off;
            r_need      <= n_need;
            r_want      <= n_want;
            r_steps     <= n_steps;
            r_fcnt      <= n_fcnt;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_status    <= n_status;
            r_newhead   <= n_newhead;
            r_index     <= n_index;
            r_addr      <= n_addr;
            r_o_status  <= n_o_status;
            r_o_newhead <= n_o_newhead;
            r_o_index   <= n_o_index;
            r_o_addr    <= n_o_addr;
            r_o_count   <= n_o_count;
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_byp_data <= wr_data;
    end

    // valid bits and forwarding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[rd_addr];
            r_byp    <= wr_en && (wr_addr == rd_addr);
        end
    end

    // checks
    `LBCM_IMPLY(a_nospace_clean, m_axis_tvalid && r_o_status == STAT_NOSPACE, r_o_count == '0 && r_o_index == NONE_MARK, "failed extend reports allocation")
    `LBCM_IMPLY(a_addr_block, m_axis_tvalid && r_o_addr != '0, r_o_addr[ADDR_W-1:OFF_W] == r_o_index[BLK_W-1:0], "byte address does not match located block")
    `LBCM_IMPLY(a_walk_bound, r_state == S_WALK && r_kind != K_LOCATE, r_steps < CNT_W'(NUM_BLOCKS), "chain walk ran past table size")
    `LBCM_IMPLY(a_alloc_bound, r_state == S_ALLOC, {1'b0, r_cnt} < r_want, "allocation went past the wanted count")

endmodule
